// ----- rtl/clock_panel_key_controller_macros.svh -----
// Assertion macros for the clock panel key controller checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef CLOCK_PANEL_KEY_CONTROLLER_MACROS_SVH
`define CLOCK_PANEL_KEY_CONTROLLER_MACROS_SVH

// same-cycle implication
`define CPKC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPKC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cpkc_pkg.sv -----
// Package for the clock panel key controller: item types, codes, constants
// and small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps

package cpkc_pkg;

  localparam int KEY_DEBOUNCE_DEF = 10;
  localparam int NAV_DEBOUNCE_DEF = 20;
  localparam int KEY_CNT_W        = 4;
  localparam int NAV_CNT_W        = 5;

  localparam logic [5:0] NAV_IDLE   = 6'd40;
  localparam logic [5:0] NAV_UP     = 6'd28;
  localparam logic [5:0] NAV_DOWN   = 6'd11;
  localparam logic [5:0] NAV_RIGHT  = 6'd5;
  localparam logic [5:0] NAV_LEFT   = 6'd23;
  localparam logic [5:0] NAV_CENTER = 6'd17;
  localparam logic [5:0] NAV_LAMP   = 6'd0;

  localparam logic [10:0] FREQ_MAX  = 11'd1080;
  localparam logic [10:0] FREQ_MIN  = 11'd875;
  localparam logic [10:0] FREQ_INIT = 11'd975;
  localparam logic [3:0]  VOL_MAX   = 4'd15;
  localparam logic [3:0]  VOL_INIT  = 4'd5;

  // cursor positions on the hh:mm:ss display
  localparam logic [2:0] CUR_HT = 3'd0;
  localparam logic [2:0] CUR_HU = 3'd1;
  localparam logic [2:0] CUR_MT = 3'd3;
  localparam logic [2:0] CUR_MU = 3'd4;
  localparam logic [2:0] CUR_ST = 3'd6;
  localparam logic [2:0] CUR_SU = 3'd7;

  localparam logic [1:0] CFG_ALARM_HOUR   = 2'd0;
  localparam logic [1:0] CFG_ALARM_MINUTE = 2'd1;
  localparam logic [1:0] CFG_ALARM_SECOND = 2'd2;

  typedef enum logic [2:0] {
    MODE_CLOCK  = 3'd1,
    MODE_SENSOR = 3'd2,
    MODE_ALARM  = 3'd3,
    MODE_RADIO  = 3'd4
  } mode_t;

  typedef logic [3:0] digit_t;
  typedef digit_t [5:0] digits_t;

  typedef struct packed {
    logic        mode_key_low;
    logic        light_key_low;
    logic [11:0] nav_level;
    logic [4:0]  now_hours;
    logic [5:0]  now_minutes;
    logic [5:0]  now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  mode_now;
    logic        editing;
    logic [2:0]  cursor_pos;
    logic        time_write;
    logic        alarm_write;
    logic [4:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [5:0]  set_seconds;
    logic [3:0]  volume_level;
    logic [10:0] tuned_freq;
    logic [7:0]  lamp_bits;
    logic        buzzer_toggle;
  } out_item_t;

  typedef struct packed {
    logic mode_act;
    logic light_act;
    logic nav_act;
  } key_act_t;

  // ladder sample / 100, exact for 12-bit samples
  function automatic logic [5:0] nav_code(input logic [11:0] lvl);
    logic [24:0] prod;
    prod = {13'd0, lvl} * 25'd5243;
    return prod[24:19];
  endfunction

  // {tens, units} of a value below 64
  function automatic logic [7:0] split_dec(input logic [5:0] v);
    logic [9:0] prod;
    logic [3:0] q;
    logic [5:0] r;
    prod = {4'd0, v} * 10'd13;
    q    = prod[10-1:7] & 4'hf;
    r    = v - 6'({2'd0, q} * 6'd10);
    return {q, r[3:0]};
  endfunction

  function automatic logic [7:0] join_dec(input digit_t t, input digit_t u);
    return ({4'd0, t} * 8'd10) + {4'd0, u};
  endfunction

endpackage

// ----- rtl/cpkc_debounce.sv -----
// Up/down counter debouncer for one key; fires once per press.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module cpkc_debounce #(
  parameter int CNT_W = 4,
  parameter int LIMIT = 10
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic pressed,
  output logic act
);

  localparam logic [CNT_W-1:0] LIM = CNT_W'(LIMIT);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rel_r, rel_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    rel_nxt = rel_r;
    act     = 1'b0;
    if (pressed) begin
      if (cnt_r < LIM) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        act     = rel_r;
        rel_nxt = 1'b0;
      end
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      rel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rel_r <= 1'b0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
      rel_r <= rel_nxt;
    end
  end

endmodule

// ----- rtl/cpkc_core.sv -----
// Panel state update for one item: mode, digit edit, radio, lamps, alarm.
// Depends on cpkc_pkg; key actions come from the debouncers.
`timescale 1ns / 1ps

module cpkc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cpkc_pkg::key_act_t  act,
  input  logic [5:0]          code,
  input  logic [4:0]          now_h,
  input  logic [5:0]          now_m,
  input  logic [5:0]          now_s,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [5:0]          cfg_val,
  output cpkc_pkg::out_item_t res
);

  cpkc_pkg::mode_t   mode_r, mode_nxt;
  logic              edit_r, edit_nxt;
  logic [2:0]        cur_r, cur_nxt;
  cpkc_pkg::digits_t dig_r, dig_a, dig_nxt;
  logic [3:0]        vol_r, vol_nxt;
  logic [10:0]       freq_r, freq_nxt;
  logic              ltog_r, ltog_nxt;
  logic              ntog_r, ntog_nxt;
  logic [7:0]        lamp_r, lamp_nxt;
  logic [4:0]        al_h_r;
  logic [5:0]        al_m_r, al_s_r;

  logic        dig_mode, tw, aw;
  logic [7:0]  ph, pm, ps, jh, jm, js;
  logic [4:0]  sh, ah, ch;
  logic [5:0]  sm, ss, am, as, cm, cs, sdiff;

  // mode sequence
  always_comb begin
    mode_nxt = mode_r;
    if (act.mode_act) begin
      case (mode_r)
        cpkc_pkg::MODE_CLOCK:  mode_nxt = cpkc_pkg::MODE_SENSOR;
        cpkc_pkg::MODE_SENSOR: mode_nxt = cpkc_pkg::MODE_ALARM;
        cpkc_pkg::MODE_ALARM:  mode_nxt = cpkc_pkg::MODE_RADIO;
        default:               mode_nxt = cpkc_pkg::MODE_CLOCK;
      endcase
    end
  end

  // digits seeded from the alarm when alarm mode is entered
  always_comb begin
    ph = cpkc_pkg::split_dec({1'b0, al_h_r});
    pm = cpkc_pkg::split_dec(al_m_r);
    ps = cpkc_pkg::split_dec(al_s_r);
    dig_a = dig_r;
    if (act.mode_act && mode_nxt == cpkc_pkg::MODE_ALARM) begin
      dig_a = {ps[3:0], ps[7:4], pm[3:0], pm[7:4], ph[3:0], ph[7:4]};
    end
  end

  // navigation keys
  always_comb begin
    logic [7:0] nh_p, nm_p, ns_p;
    nh_p     = cpkc_pkg::split_dec({1'b0, now_h});
    nm_p     = cpkc_pkg::split_dec(now_m);
    ns_p     = cpkc_pkg::split_dec(now_s);
    dig_mode = (mode_nxt == cpkc_pkg::MODE_CLOCK) || (mode_nxt == cpkc_pkg::MODE_ALARM);
    dig_nxt  = dig_a;
    cur_nxt  = cur_r;
    vol_nxt  = vol_r;
    freq_nxt = freq_r;
    edit_nxt = edit_r;
    ntog_nxt = ntog_r;
    tw       = 1'b0;
    aw       = 1'b0;
    if (act.nav_act) begin
      if (code == cpkc_pkg::NAV_UP) begin
        if (dig_mode) begin
          case (cur_r)
            cpkc_pkg::CUR_HT: dig_nxt[0] = (dig_a[0] < 4'd2) ? dig_a[0] + 4'd1 : 4'd0;
            cpkc_pkg::CUR_HU: begin
              if (dig_a[0] < 4'd2 && dig_a[1] < 4'd10) begin
                dig_nxt[1] = (dig_a[1] == 4'd9) ? 4'd0 : dig_a[1] + 4'd1;
              end else if (dig_a[0] == 4'd2 && dig_a[1] < 4'd4) begin
                dig_nxt[1] = (dig_a[1] == 4'd3) ? 4'd0 : dig_a[1] + 4'd1;
              end else begin
                dig_nxt[1] = 4'd0;
              end
            end
            cpkc_pkg::CUR_MT: dig_nxt[2] = (dig_a[2] < 4'd5) ? dig_a[2] + 4'd1 : 4'd0;
            cpkc_pkg::CUR_MU: dig_nxt[3] = (dig_a[3] < 4'd9) ? dig_a[3] + 4'd1 : 4'd0;
            cpkc_pkg::CUR_ST: dig_nxt[4] = (dig_a[4] < 4'd5) ? dig_a[4] + 4'd1 : 4'd0;
            cpkc_pkg::CUR_SU: dig_nxt[5] = (dig_a[5] < 4'd9) ? dig_a[5] + 4'd1 : 4'd0;
            default: dig_nxt = dig_a;
          endcase
        end else if (mode_nxt == cpkc_pkg::MODE_RADIO) begin
          vol_nxt = (vol_r >= cpkc_pkg::VOL_MAX) ? 4'd0 : vol_r + 4'd1;
        end
      end else if (code == cpkc_pkg::NAV_DOWN) begin
        if (dig_mode) begin
          case (cur_r)
            cpkc_pkg::CUR_HT: dig_nxt[0] = (dig_a[0] != 4'd0) ? dig_a[0] - 4'd1 : 4'd2;
            cpkc_pkg::CUR_HU: begin
              if (dig_a[0] < 4'd2) begin
                dig_nxt[1] = (dig_a[1] != 4'd0) ? dig_a[1] - 4'd1 : 4'd9;
              end else if (dig_a[0] == 4'd2) begin
                dig_nxt[1] = (dig_a[1] != 4'd0) ? dig_a[1] - 4'd1 : 4'd3;
              end
            end
            cpkc_pkg::CUR_MT: dig_nxt[2] = (dig_a[2] != 4'd0) ? dig_a[2] - 4'd1 : 4'd5;
            cpkc_pkg::CUR_MU: dig_nxt[3] = (dig_a[3] != 4'd0) ? dig_a[3] - 4'd1 : 4'd9;
            cpkc_pkg::CUR_ST: dig_nxt[4] = (dig_a[4] != 4'd0) ? dig_a[4] - 4'd1 : 4'd5;
            cpkc_pkg::CUR_SU: dig_nxt[5] = (dig_a[5] != 4'd0) ? dig_a[5] - 4'd1 : 4'd9;
            default: dig_nxt = dig_a;
          endcase
        end else if (mode_nxt == cpkc_pkg::MODE_RADIO) begin
          vol_nxt = (vol_r != 4'd0) ? vol_r - 4'd1 : cpkc_pkg::VOL_MAX;
        end
      end else if (code == cpkc_pkg::NAV_RIGHT) begin
        if (dig_mode) begin
          if (cur_r == cpkc_pkg::CUR_HU || cur_r == cpkc_pkg::CUR_MU) begin
            cur_nxt = cur_r + 3'd2;
          end else if (cur_r < cpkc_pkg::CUR_SU) begin
            cur_nxt = cur_r + 3'd1;
          end else begin
            cur_nxt = cpkc_pkg::CUR_HT;
          end
        end else if (mode_nxt == cpkc_pkg::MODE_RADIO) begin
          freq_nxt = (freq_r >= cpkc_pkg::FREQ_MAX) ? cpkc_pkg::FREQ_MIN : freq_r + 11'd1;
        end
      end else if (code == cpkc_pkg::NAV_LEFT) begin
        if (dig_mode) begin
          if (cur_r == cpkc_pkg::CUR_MT || cur_r == cpkc_pkg::CUR_ST) begin
            cur_nxt = cur_r - 3'd2;
          end else if (cur_r != cpkc_pkg::CUR_HT) begin
            cur_nxt = cur_r - 3'd1;
          end else begin
            cur_nxt = cpkc_pkg::CUR_SU;
          end
        end else if (mode_nxt == cpkc_pkg::MODE_RADIO) begin
          freq_nxt = (freq_r <= cpkc_pkg::FREQ_MIN) ? cpkc_pkg::FREQ_MAX : freq_r - 11'd1;
        end
      end else if (code == cpkc_pkg::NAV_CENTER) begin
        edit_nxt = ~edit_r;
        if (edit_nxt && mode_nxt == cpkc_pkg::MODE_CLOCK) begin
          dig_nxt = {ns_p[3:0], ns_p[7:4], nm_p[3:0], nm_p[7:4], nh_p[3:0], nh_p[7:4]};
        end else if (!edit_nxt && mode_nxt == cpkc_pkg::MODE_CLOCK) begin
          tw = 1'b1;
        end else if (!edit_nxt && mode_nxt == cpkc_pkg::MODE_ALARM) begin
          aw = 1'b1;
        end
      end else if (code == cpkc_pkg::NAV_LAMP) begin
        ntog_nxt = ~ntog_r;
      end
    end
  end

  // lamps: low nibble follows the light key, high nibble the nav lamp key
  always_comb begin
    ltog_nxt = act.light_act ? ~ltog_r : ltog_r;
    lamp_nxt = lamp_r;
    if (act.light_act) begin
      lamp_nxt[3:0] = {4{ltog_nxt}};
    end
    if (act.nav_act && code == cpkc_pkg::NAV_LAMP) begin
      lamp_nxt[7:4] = {4{ntog_nxt}};
    end
  end

  // assembled values, alarm match
  always_comb begin
    jh    = cpkc_pkg::join_dec(dig_nxt[0], dig_nxt[1]);
    jm    = cpkc_pkg::join_dec(dig_nxt[2], dig_nxt[3]);
    js    = cpkc_pkg::join_dec(dig_nxt[4], dig_nxt[5]);
    sh    = jh[4:0];
    sm    = jm[5:0];
    ss    = js[5:0];
    ah    = aw ? sh : al_h_r;
    am    = aw ? sm : al_m_r;
    as    = aw ? ss : al_s_r;
    ch    = tw ? sh : now_h;
    cm    = tw ? sm : now_m;
    cs    = tw ? ss : now_s;
    sdiff = cs - as;
  end

  always_comb begin
    res.mode_now      = mode_nxt;
    res.editing       = edit_nxt;
    res.cursor_pos    = cur_nxt;
    res.time_write    = tw;
    res.alarm_write   = aw;
    res.set_hours     = sh;
    res.set_minutes   = sm;
    res.set_seconds   = ss;
    res.volume_level  = vol_nxt;
    res.tuned_freq    = freq_nxt;
    res.lamp_bits     = lamp_nxt;
    res.buzzer_toggle = (ch == ah) && (cm == am) && (cs >= as) && (sdiff <= 6'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cpkc_pkg::MODE_CLOCK;
      edit_r <= 1'b0;
      cur_r  <= cpkc_pkg::CUR_SU;
      dig_r  <= '0;
      vol_r  <= cpkc_pkg::VOL_INIT;
      freq_r <= cpkc_pkg::FREQ_INIT;
      ltog_r <= 1'b0;
      ntog_r <= 1'b0;
      lamp_r <= '0;
    end else if (en) begin
      mode_r <= mode_nxt;
      edit_r <= edit_nxt;
      cur_r  <= cur_nxt;
      dig_r  <= dig_nxt;
      vol_r  <= vol_nxt;
      freq_r <= freq_nxt;
      ltog_r <= ltog_nxt;
      ntog_r <= ntog_nxt;
      lamp_r <= lamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      al_h_r <= '0;
      al_m_r <= '0;
      al_s_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        cpkc_pkg::CFG_ALARM_HOUR:   al_h_r <= cfg_val[4:0];
        cpkc_pkg::CFG_ALARM_MINUTE: al_m_r <= cfg_val;
        cpkc_pkg::CFG_ALARM_SECOND: al_s_r <= cfg_val;
        default: ;
      endcase
    end else if (en && aw) begin
      al_h_r <= sh;
      al_m_r <= sm;
      al_s_r <= ss;
    end
  end

endmodule

// ----- rtl/clock_panel_key_controller.sv -----
// Clock panel key controller: one item per tick of keys, ladder sample and
// current time; one result item per input item.
//
// Input channel (in_valid / in_stall / in_data): one item per 1 ms tick.
// Result channel (out_valid / out_stall / out_data): one result per item,
// carrying mode, edit state, cursor, write strobes, assembled set time,
// volume, frequency, lamp byte and buzzer flag after that tick.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
// alarm hour, minute or second; always ready; write only while idle.
// An accepted item waits in the input register until the result register is
// free or being taken; its result is then registered in the result register.
// Throughput: one item per cycle while out_stall is low; input and result
// registers hold one item each, and all per-item work sits between them.
// When out_stall holds, the result register keeps its item and in_stall
// rises once the input register is also full.
// Reset (rst_n low, synchronous): both channels empty, mode clock, volume 5,
// frequency 975, cursor on seconds units, alarm 00:00:00, keys armed only
// after each has been seen released.
// Depends on cpkc_pkg, cpkc_debounce and cpkc_core.
`timescale 1ns / 1ps

module clock_panel_key_controller #(
  parameter int KEY_DEBOUNCE = cpkc_pkg::KEY_DEBOUNCE_DEF,
  parameter int NAV_DEBOUNCE = cpkc_pkg::NAV_DEBOUNCE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cpkc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cpkc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [5:0]          cfg_data
);

  logic                s1_valid_r, s1_valid_nxt;
  cpkc_pkg::in_item_t  s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  cpkc_pkg::out_item_t out_item_r;
  logic                adv, in_acc;
  logic [5:0]          code;
  cpkc_pkg::key_act_t  act;
  cpkc_pkg::out_item_t res;

  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign code      = cpkc_pkg::nav_code(s1_item_r.nav_level);

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  cpkc_debounce #(.CNT_W(cpkc_pkg::KEY_CNT_W), .LIMIT(KEY_DEBOUNCE)) u_mode_db (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .pressed(s1_item_r.mode_key_low), .act(act.mode_act)
  );

  cpkc_debounce #(.CNT_W(cpkc_pkg::KEY_CNT_W), .LIMIT(KEY_DEBOUNCE)) u_light_db (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .pressed(s1_item_r.light_key_low), .act(act.light_act)
  );

  cpkc_debounce #(.CNT_W(cpkc_pkg::NAV_CNT_W), .LIMIT(NAV_DEBOUNCE)) u_nav_db (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .pressed(code != cpkc_pkg::NAV_IDLE), .act(act.nav_act)
  );

  cpkc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .act     (act),
    .code    (code),
    .now_h   (s1_item_r.now_hours),
    .now_m   (s1_item_r.now_minutes),
    .now_s   (s1_item_r.now_seconds),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

endmodule

// ----- rtl/cpkc_checker.sv -----
// Port-level checks for the clock panel key controller, bound to the top.
// Depends on cpkc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "clock_panel_key_controller_macros.svh"

module cpkc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input cpkc_pkg::out_item_t out_data
);

  `CPKC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result item changed")
  `CPKC_ASSERT_IMP(a_strobe_excl, out_valid, !(out_data.time_write && out_data.alarm_write), "time and alarm write together")
  `CPKC_ASSERT_IMP(a_strobe_edit, out_valid && (out_data.time_write || out_data.alarm_write), !out_data.editing, "write strobe while editing")
  `CPKC_ASSERT_IMP(a_cursor, out_valid, out_data.cursor_pos != 3'd2 && out_data.cursor_pos != 3'd5, "cursor on separator")
  `CPKC_ASSERT_IMP(a_freq, out_valid, out_data.tuned_freq >= cpkc_pkg::FREQ_MIN && out_data.tuned_freq <= cpkc_pkg::FREQ_MAX, "frequency out of band")

endmodule

bind clock_panel_key_controller cpkc_checker u_cpkc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
